### hw/rtl/mgenc_pkg.sv
package mgenc_pkg;

  // Field prime 2^63 - 25 and the rejection bound 2^64 - 50 (twice the prime)
  localparam logic [62:0] PRIME      = 63'h7FFF_FFFF_FFFF_FFE7;
  localparam logic [63:0] DRAW_LIMIT = 64'hFFFF_FFFF_FFFF_FFCE;

  // Twister constants
  localparam int unsigned MT_N       = 624;
  localparam int unsigned MT_M       = 397;
  localparam int unsigned MT_WRAP    = MT_N - MT_M;
  localparam logic [31:0] MT_MATRIX  = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;

  // Configuration register indexes
  localparam logic [1:0] REG_SEED_ALPHA = 2'd0;
  localparam logic [1:0] REG_SEED_BETA  = 2'd1;
  localparam logic [1:0] REG_SEED_SELF  = 2'd2;
  localparam logic [1:0] REG_HASH       = 2'd3;

  typedef struct packed {
    logic seed;
    logic draw;
  } tw_ctrl_t;

  typedef struct packed {
    logic busy;
  } tw_stat_t;

  // Output tempering of one twister word
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Sum of two residues, reduced once
  function automatic logic [62:0] add_mod(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[62:0];
  endfunction

  // True residue of a two's complement value
  function automatic logic [62:0] res_signed(input logic [63:0] g);
    logic [64:0] s;
    s = {g[63], g};
    if (!g[63]) begin
      if (s >= {2'b00, PRIME}) begin
        s = s - {2'b00, PRIME};
      end
    end else begin
      s = s + {2'b00, PRIME};
      if (s[64]) begin
        s = s + {2'b00, PRIME};
      end
    end
    return s[62:0];
  endfunction

endpackage

### hw/rtl/mgenc_twister.sv
module mgenc_twister (
  input  logic                clk,
  input  logic                rst_n,
  input  mgenc_pkg::tw_ctrl_t ctrl,
  input  logic [31:0]         seed,
  output mgenc_pkg::tw_stat_t stat,
  output logic [62:0]         mask
);

  localparam logic [2:0] TW_IDLE = 3'd0;
  localparam logic [2:0] TW_SEED = 3'd1;
  localparam logic [2:0] TW_HI   = 3'd2;
  localparam logic [2:0] TW_LO   = 3'd3;
  localparam logic [2:0] TW_LAST = 3'd4;
  localparam logic [2:0] TW_CHK  = 3'd5;

  localparam logic [9:0] LAST_POS = 10'(mgenc_pkg::MT_N - 1);
  localparam logic [9:0] WRAP_POS = 10'(mgenc_pkg::MT_WRAP);
  localparam logic [9:0] M_OFS    = 10'(mgenc_pkg::MT_M);

  logic [31:0] twister_mem [mgenc_pkg::MT_N];

  logic [2:0]  state_r, state_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [9:0]  wb_pos_r, wb_pos_nxt;
  logic [9:0]  cnt_r, cnt_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] cache_r, cache_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [62:0] mask_r, mask_nxt;
  logic [31:0] rd_a_r, rd_b_r;

  logic [9:0]  addr_a, addr_b;
  logic        we;
  logic [9:0]  waddr;
  logic [31:0] wdata;
  logic [31:0] y;
  logic [31:0] gen;
  logic [31:0] seed_nv;
  logic [63:0] draw_v;

  // Read addresses of the step at pos_r: next word and the word M ahead
  assign addr_a = (pos_r == LAST_POS) ? 10'd0 : pos_r + 10'd1;
  assign addr_b = (pos_r < WRAP_POS) ? pos_r + M_OFS : pos_r - WRAP_POS;

  // Regenerate one word from cached word, next word and word M ahead
  assign y   = {cache_r[31], rd_a_r[30:0]};
  assign gen = rd_b_r ^ {1'b0, y[31:1]} ^ (y[0] ? mgenc_pkg::MT_MATRIX : 32'd0);

  // Seeding recurrence
  assign seed_nv = mgenc_pkg::SEED_MULT * (p_r ^ (p_r >> 30)) + {22'd0, cnt_r};

  assign draw_v = {hi_r, lo_r};

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    wb_pos_nxt = wb_pos_r;
    cnt_nxt    = cnt_r;
    p_nxt      = p_r;
    cache_nxt  = cache_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    mask_nxt   = mask_r;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = seed_nv;
    case (state_r)
      TW_IDLE: begin
        if (ctrl.seed) begin
          we        = 1'b1;
          waddr     = 10'd0;
          wdata     = seed;
          p_nxt     = seed;
          cache_nxt = seed;
          pos_nxt   = 10'd0;
          cnt_nxt   = 10'd1;
          state_nxt = TW_SEED;
        end else if (ctrl.draw) begin
          state_nxt = TW_HI;
        end
      end
      TW_SEED: begin
        we    = 1'b1;
        p_nxt = seed_nv;
        if (cnt_r == LAST_POS) begin
          state_nxt = TW_IDLE;
        end else begin
          cnt_nxt = cnt_r + 10'd1;
        end
      end
      TW_HI: begin
        wb_pos_nxt = pos_r;
        pos_nxt    = addr_a;
        state_nxt  = TW_LO;
      end
      TW_LO: begin
        we         = 1'b1;
        waddr      = wb_pos_r;
        wdata      = gen;
        cache_nxt  = rd_a_r;
        hi_nxt     = mgenc_pkg::temper(gen);
        wb_pos_nxt = pos_r;
        pos_nxt    = addr_a;
        state_nxt  = TW_LAST;
      end
      TW_LAST: begin
        we        = 1'b1;
        waddr     = wb_pos_r;
        wdata     = gen;
        cache_nxt = rd_a_r;
        lo_nxt    = mgenc_pkg::temper(gen);
        state_nxt = TW_CHK;
      end
      TW_CHK: begin
        // Drop draws at or above twice the prime, else reduce once
        if (draw_v >= mgenc_pkg::DRAW_LIMIT) begin
          state_nxt = TW_HI;
        end else begin
          if (draw_v >= {1'b0, mgenc_pkg::PRIME}) begin
            mask_nxt = 63'(draw_v - {1'b0, mgenc_pkg::PRIME});
          end else begin
            mask_nxt = draw_v[62:0];
          end
          state_nxt = TW_IDLE;
        end
      end
      default: begin
        state_nxt = TW_IDLE;
      end
    endcase
  end

  // Word store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      twister_mem[waddr] <= wdata;
    end
    rd_a_r <= twister_mem[addr_a];
    rd_b_r <= twister_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TW_IDLE;
      pos_r   <= 10'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_pos_r <= wb_pos_nxt;
    cnt_r    <= cnt_nxt;
    p_r      <= p_nxt;
    cache_r  <= cache_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    mask_r   <= mask_nxt;
  end

  assign stat.busy = (state_r != TW_IDLE);
  assign mask      = mask_r;

endmodule

### hw/rtl/masked_gradient_encoder_unit.sv
// Flow: a mask draw, a bit-serial modular multiply, three modular adds and one
//   output load. A new request is taken only in idle, once the result is loaded;
//   a restart first reseeds the word stores, and a rejected draw is redrawn.
// Reset (synchronous, rst_n low) clears control state, configuration registers and positions;
//   the word stores hold no defined value until the first restart.
module masked_gradient_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_scaled_gradient,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] out_masked_value,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] seed_alpha_r, seed_beta_r, seed_self_r;
  logic [62:0] hash_r;
  logic [63:0] grad_r;
  logic [62:0] hash_res_r, hash_res_nxt;
  logic [62:0] acc_r, acc_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  logic [1:0]  add_k_r, add_k_nxt;
  logic        out_valid_r;
  logic [62:0] out_value_r;

  mgenc_pkg::tw_ctrl_t tw_ctrl;
  mgenc_pkg::tw_stat_t st_alpha, st_beta, st_self;
  logic [62:0] mask_alpha, mask_beta, mask_self;
  logic        tw_busy;
  logic        accept;
  logic        out_free;
  logic [62:0] dbl;
  logic [62:0] add_op;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign tw_busy  = st_alpha.busy || st_beta.busy || st_self.busy;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_alpha_r <= 32'd0;
      seed_beta_r  <= 32'd0;
      seed_self_r  <= 32'd0;
      hash_r       <= 63'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mgenc_pkg::REG_SEED_ALPHA: seed_alpha_r <= cfg_data[31:0];
        mgenc_pkg::REG_SEED_BETA:  seed_beta_r  <= cfg_data[31:0];
        mgenc_pkg::REG_SEED_SELF:  seed_self_r  <= cfg_data[31:0];
        mgenc_pkg::REG_HASH:       hash_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Seed or draw on all three twisters together
  always_comb begin
    tw_ctrl.seed = accept && in_restart;
    tw_ctrl.draw = (accept && !in_restart) || (state_r == S_SEED && !tw_busy);
  end

  mgenc_twister u_alpha (
    .clk (clk), .rst_n (rst_n), .ctrl (tw_ctrl), .seed (seed_alpha_r),
    .stat (st_alpha), .mask (mask_alpha)
  );

  mgenc_twister u_beta (
    .clk (clk), .rst_n (rst_n), .ctrl (tw_ctrl), .seed (seed_beta_r),
    .stat (st_beta), .mask (mask_beta)
  );

  mgenc_twister u_self (
    .clk (clk), .rst_n (rst_n), .ctrl (tw_ctrl), .seed (seed_self_r),
    .stat (st_self), .mask (mask_self)
  );

  // One bit of the hash per multiply step, most significant first
  assign dbl = mgenc_pkg::add_mod(acc_r, acc_r);

  always_comb begin
    case (add_k_r)
      2'd0:    add_op = mgenc_pkg::res_signed(grad_r);
      2'd1:    add_op = mask_beta;
      default: add_op = mask_self;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    hash_res_nxt = hash_res_r;
    acc_nxt      = acc_r;
    bit_cnt_nxt  = bit_cnt_r;
    add_k_nxt    = add_k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_restart ? S_SEED : S_DRAW;
        end
      end
      S_SEED: begin
        if (!tw_busy) begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        if (!tw_busy) begin
          hash_res_nxt = (hash_r >= mgenc_pkg::PRIME) ? hash_r - mgenc_pkg::PRIME : hash_r;
          acc_nxt      = 63'd0;
          bit_cnt_nxt  = 6'd62;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt = hash_res_r[bit_cnt_r] ? mgenc_pkg::add_mod(dbl, mask_alpha) : dbl;
        if (bit_cnt_r == 6'd0) begin
          add_k_nxt = 2'd0;
          state_nxt = S_ADD;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 6'd1;
        end
      end
      S_ADD: begin
        acc_nxt = mgenc_pkg::add_mod(acc_r, add_op);
        if (add_k_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          add_k_nxt = add_k_r + 2'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grad_r <= in_scaled_gradient;
    end
    hash_res_r <= hash_res_nxt;
    acc_r      <= acc_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    add_k_r    <= add_k_nxt;
  end

  // Output register: load on finish, drop on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_value_r <= acc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_masked_value = out_value_r;

  a_mul_twisters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_ADD) |-> !tw_busy)
    else $error("twister busy during multiply or add");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < mgenc_pkg::PRIME))
    else $error("result not reduced");

  a_mul_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && bit_cnt_r == 6'd0) |=> (state_r == S_ADD))
    else $error("multiply did not end after last bit");

endmodule
